@@ design/psd_pkg.sv @@
// Shared types, constants and helpers for the packed index symbol decoder.
package psd_pkg;

    localparam int unsigned SYM_COUNT_W    = 5;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned MAX_TABLE      = 16;
    localparam int unsigned DEF_TABLE      = 16;
    localparam int unsigned STREAM_W       = 11;  // up to 3 residual bits plus one byte
    localparam int unsigned RESID_W        = 3;
    localparam int unsigned RESID_CNT_W    = 2;
    localparam int unsigned WIDTH_W        = 3;
    localparam int unsigned COUNT_W        = 4;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [SYM_COUNT_W-1:0] SYM_COUNT_RESET = SYM_COUNT_W'(2);

    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_HIGH   = 2'd2;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       run_end;
    } t_out_item;

    // One classified byte: the bit stream in read order, index width, index count.
    typedef struct packed {
        logic [STREAM_W-1:0] stream;
        logic [WIDTH_W-1:0]  width;
        logic [COUNT_W-1:0]  count;
    } t_job;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

    function automatic logic [3:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [3:0] m;
        case (w)
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

@@ design/psd_stream_if.sv @@
// Valid/ready channel carrying one payload of a chosen type.
interface psd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/psd_front.sv @@
// Front end: accepts packed bytes, merges residual bits and works out the indices.
module psd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psd_pkg::t_cfg_wr i_cfg,
    psd_stream_if.sink       i_in,
    psd_stream_if.source     o_job
);
    import psd_pkg::*;

    logic [SYM_COUNT_W-1:0] r_symbol_count;
    logic [RESID_W-1:0]     r_resid_bits;
    logic [RESID_CNT_W-1:0] r_resid_count;
    logic [RESID_W-1:0]     n_resid_bits;
    logic [RESID_CNT_W-1:0] n_resid_count;

    logic [WIDTH_W-1:0]  w;
    logic [RESID_W-1:0]  acc;
    logic [RESID_CNT_W-1:0] have;
    logic [7:0]          byte_rev;
    logic [STREAM_W-1:0] stream;
    logic [3:0]          total;
    logic [COUNT_W-1:0]  cnt;
    logic [6:0]          used_full;
    logic [3:0]          used;
    logic [3:0]          remain;
    logic [STREAM_W-1:0] left;
    logic                accept;

    always_comb begin
        if (r_symbol_count < SYM_COUNT_W'(3))      w = 3'd1;
        else if (r_symbol_count < SYM_COUNT_W'(5)) w = 3'd2;
        else if (r_symbol_count < SYM_COUNT_W'(9)) w = 3'd3;
        else                                        w = 3'd4;
    end

    always_comb begin
        // a residual as wide as the current index width is stale
        if ({1'b0, r_resid_count} >= w) begin
            acc  = '0;
            have = '0;
        end else begin
            acc  = r_resid_bits;
            have = r_resid_count;
        end
        for (int k = 0; k < 8; k++) begin
            byte_rev[k] = i_in.payload.packed_byte[7-k];
        end
        stream = STREAM_W'(acc) | (STREAM_W'(byte_rev) << have);
        total  = 4'd8 + 4'(have);
        case (w)
            3'd1:    cnt = total;
            3'd2:    cnt = total >> 1;
            3'd3:    cnt = (total >= 4'd9) ? 4'd3 : 4'd2;
            default: cnt = total >> 2;
        endcase
        used_full = 7'(cnt) * 7'(w);
        used      = used_full[3:0];
        remain    = total - used;
        left      = stream >> used;
    end

    assign accept = i_in.valid && i_in.ready;

    assign i_in.ready         = o_job.ready;
    assign o_job.valid        = i_in.valid && (cnt != '0);
    assign o_job.payload.stream = stream;
    assign o_job.payload.width  = w;
    assign o_job.payload.count  = cnt;

    always_comb begin
        n_resid_bits  = r_resid_bits;
        n_resid_count = r_resid_count;
        if (i_cfg.we && i_cfg.index == CFG_SYMBOL_COUNT) begin
            n_resid_bits  = '0;
            n_resid_count = '0;
        end else if (accept) begin
            if (i_in.payload.final_byte) begin
                n_resid_bits  = '0;
                n_resid_count = '0;
            end else begin
                n_resid_bits  = left[RESID_W-1:0];
                n_resid_count = remain[RESID_CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= SYM_COUNT_RESET;
            r_resid_bits   <= '0;
            r_resid_count  <= '0;
        end else begin
            if (i_cfg.we && i_cfg.index == CFG_SYMBOL_COUNT) begin
                r_symbol_count <= i_cfg.data[SYM_COUNT_W-1:0];
            end
            r_resid_bits  <= n_resid_bits;
            r_resid_count <= n_resid_count;
        end
    end

endmodule

@@ design/psd_queue.sv @@
// Short FIFO of classified bytes between the front and back ends.
module psd_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psd_stream_if.sink   i_push,
    psd_stream_if.source o_pop
);
    import psd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign i_push.ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop.valid   = (r_count != '0);
    assign o_pop.payload = r_mem[r_rptr];
    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

endmodule

@@ design/psd_back.sv @@
// Back end: cuts indices from queued jobs, emitting one table symbol per cycle while fed and not stalled.
module psd_back #(
    parameter int unsigned TABLE_ENTRIES = psd_pkg::DEF_TABLE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psd_pkg::t_cfg_wr i_cfg,
    psd_stream_if.sink       i_job,
    psd_stream_if.source     o_out
);
    import psd_pkg::*;

    logic [CFG_DATA_W-1:0] r_table_low;
    logic [CFG_DATA_W-1:0] r_table_high;
    logic [COUNT_W-1:0]    r_pos;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [6:0] shift_full;
    logic [3:0] shift;
    logic [STREAM_W-1:0] shifted;
    logic [3:0] idx;
    logic [7:0] sym;
    logic       last;
    logic       advance;

    always_comb begin
        shift_full = 7'(r_pos) * 7'(i_job.payload.width);
        shift      = shift_full[3:0];
        shifted    = i_job.payload.stream >> shift;
        idx        = shifted[3:0] & width_mask(i_job.payload.width);
        if (5'(idx) >= 5'(TABLE_ENTRIES)) sym = '0;
        else if (!idx[3])                 sym = r_table_low[{idx[2:0], 3'b000} +: 8];
        else                              sym = r_table_high[{idx[2:0], 3'b000} +: 8];
        last    = (r_pos == i_job.payload.count - 1'b1);
        advance = i_job.valid && (!r_out_valid || o_out.ready);
    end

    assign i_job.ready   = advance && last;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cfg.we && i_cfg.index == CFG_TABLE_LOW)  r_table_low  <= i_cfg.data;
        if (i_cfg.we && i_cfg.index == CFG_TABLE_HIGH) r_table_high <= i_cfg.data;
        if (advance) begin
            r_out.symbol  <= sym;
            r_out.run_end <= last;
        end
        if (!i_rst_n) begin
            r_table_low  <= '0;
            r_table_high <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_pos <= last ? '0 : r_pos + 1'b1;
            end
            if (advance)           r_out_valid <= 1'b1;
            else if (o_out.ready)  r_out_valid <= 1'b0;
        end
    end

endmodule

@@ design/packed_index_symbol_decoder.sv @@
// Packed index symbol decoder: takes one compressed byte per transfer and emits the table
// symbols of the indices completed by it, one symbol per cycle from the back end while the
// output is ready. A byte completes 8 indices at 1-bit width, 4 at 2 bits, 2 or 3 at 3
// bits and 2 at 4 bits. The front end accepts a new byte each cycle while the two-entry
// queue has room, so the sustained rate is set by the back end's one-symbol-per-cycle
// output register.
module packed_index_symbol_decoder #(
    parameter int unsigned TABLE_ENTRIES = psd_pkg::DEF_TABLE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    psd_stream_if.sink                          i_packed,
    psd_stream_if.source                        o_symbols
);
    import psd_pkg::*;

    t_cfg_wr cfg;

    psd_stream_if #(.t_payload(t_job)) front_to_queue ();
    psd_stream_if #(.t_payload(t_job)) queue_to_back ();

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_packed),
        .o_job   (front_to_queue)
    );

    psd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_to_queue),
        .o_pop   (queue_to_back)
    );

    psd_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_job   (queue_to_back),
        .o_out   (o_symbols)
    );

endmodule
